### rtl/math_expression_tokenizer_assert.svh
// Assertion macros shared by the tokenizer checker
`ifndef MATH_EXPRESSION_TOKENIZER_ASSERT_SVH
`define MATH_EXPRESSION_TOKENIZER_ASSERT_SVH

// Same-cycle implication, muted while reset is high
`define MET_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer same-cycle check failed");

// Next-cycle implication, muted while reset is high
`define MET_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer next-cycle check failed");

`endif

### rtl/met_pkg.sv
// Shared types, codes and constants of the expression tokenizer
package met_pkg;

   localparam int CHAR_W  = 8;
   localparam int MANT_W  = 60;
   localparam int FRAC_W  = 5;
   localparam int EPOS_W  = 16;
   localparam int COUNT_W = 5;

   localparam int MAX_DIGITS_DEF = 18;
   localparam int INDEX_BITS_DEF = 16;
   localparam logic [FRAC_W-1:0] FRAC_CEIL = 5'd18;

   localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_MUL    = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_DIV    = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_POWER  = 8'h5E;
   localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
   localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
   localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
   localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;

   localparam logic [23:0] WORD_SIN  = "sin";
   localparam logic [23:0] WORD_COS  = "cos";
   localparam logic [23:0] WORD_TAN  = "tan";
   localparam logic [31:0] WORD_SQRT = "sqrt";

   typedef enum logic [3:0] {
      KIND_PLUS, KIND_MINUS, KIND_MUL, KIND_DIV, KIND_POWER, KIND_LPAREN,
      KIND_RPAREN, KIND_NUMBER, KIND_SIN, KIND_COS, KIND_TAN, KIND_SQRT, KIND_ERROR
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE, ERR_UNEXPECTED, ERR_SECOND_DOT, ERR_UNKNOWN_FN, ERR_TOO_MANY
   } ecode_type;

   typedef struct packed {
      kind_type            kind;
      logic [MANT_W-1:0]   mantissa;
      logic [FRAC_W-1:0]   frac;
      ecode_type           ecode;
      logic [EPOS_W-1:0]   epos;
   } result_type;

   // up to two tokens caused by one character
   typedef struct packed {
      logic [1:0]  count;
      result_type  first;
      result_type  second;
   } pair_type;

endpackage

### rtl/met_if.sv
// Request and response channel interfaces of the expression tokenizer
interface met_req_if import met_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              end_of_expression;

   modport source (output valid, char_code, end_of_expression, input ready);
   modport sink   (input valid, char_code, end_of_expression, output ready);
endinterface

interface met_rsp_if import met_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [3:0]        token_kind;
   logic [MANT_W-1:0] number_mantissa;
   logic [FRAC_W-1:0] fraction_digits;
   logic [2:0]        error_code;
   logic [EPOS_W-1:0] error_position;
   logic              last_of_run;

   modport source (output valid, token_kind, number_mantissa, fraction_digits,
                   error_code, error_position, last_of_run, input ready);
   modport sink   (input valid, token_kind, number_mantissa, fraction_digits,
                   error_code, error_position, last_of_run, output ready);
endinterface

### rtl/met_lexer.sv
// Scanner state and per-character token logic
module met_lexer import met_pkg::*; #(
   parameter int MAX_DIGITS = MAX_DIGITS_DEF,
   parameter int INDEX_BITS = INDEX_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [CHAR_W-1:0] char_code,
   input  logic              end_of_expression,
   output pair_type          pair
);

   typedef enum logic [1:0] {PH_IDLE, PH_NUM, PH_WORD, PH_ERR} phase_type;

   localparam logic [2:0] WORD_FULL = 3'd4;
   localparam logic [2:0] WORD_OVER = 3'd5;

   phase_type               phase_ff, phase_in;
   logic [MANT_W-1:0]       acc_ff, acc_in;
   logic [COUNT_W-1:0]      dcount_ff, dcount_in;
   logic [FRAC_W-1:0]       adot_ff, adot_in;
   logic                    dot_ff, dot_in;
   logic [CHAR_W-1:0]       letters_ff [4];
   logic [CHAR_W-1:0]       letters_in [4];
   logic [2:0]              wlen_ff, wlen_in;
   logic [INDEX_BITS-1:0]   index_ff, index_in;

   logic                    handled;
   logic                    is_digit, is_letter, is_dot;
   logic [3:0]              dval;
   logic [INDEX_BITS-1:0]   idx_prev;
   kind_type                fn_kind;

   function automatic result_type make_res(kind_type k, logic [MANT_W-1:0] m,
                                           logic [FRAC_W-1:0] f, ecode_type e,
                                           logic [EPOS_W-1:0] p);
      result_type r;
      r.kind     = k;
      r.mantissa = m;
      r.frac     = f;
      r.ecode    = e;
      r.epos     = p;
      return r;
   endfunction

   function automatic pair_type push(pair_type p, result_type r);
      pair_type q;
      q = p;
      if (p.count == 2'd0) begin
         q.first = r;
      end else begin
         q.second = r;
      end
      q.count = p.count + 2'd1;
      return q;
   endfunction

   function automatic kind_type word_kind(logic [CHAR_W-1:0] l0, logic [CHAR_W-1:0] l1,
                                          logic [CHAR_W-1:0] l2, logic [CHAR_W-1:0] l3,
                                          logic [2:0] len);
      kind_type k;
      k = KIND_ERROR;
      if (len == 3'd3 && {l0, l1, l2} == WORD_SIN) k = KIND_SIN;
      else if (len == 3'd3 && {l0, l1, l2} == WORD_COS) k = KIND_COS;
      else if (len == 3'd3 && {l0, l1, l2} == WORD_TAN) k = KIND_TAN;
      else if (len == 3'd4 && {l0, l1, l2, l3} == WORD_SQRT) k = KIND_SQRT;
      return k;
   endfunction

   assign is_digit  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
   assign is_letter = ((char_code >= 8'h61) && (char_code <= 8'h7A)) ||
                      ((char_code >= 8'h41) && (char_code <= 8'h5A));
   assign is_dot    = (char_code == CH_DOT);
   assign dval      = char_code[3:0];
   assign idx_prev  = index_ff - INDEX_BITS'(1);
   assign fn_kind   = word_kind(letters_ff[0], letters_ff[1], letters_ff[2],
                                letters_ff[3], wlen_ff);

   always_comb begin
      phase_in   = phase_ff;
      acc_in     = acc_ff;
      dcount_in  = dcount_ff;
      adot_in    = adot_ff;
      dot_in     = dot_ff;
      letters_in = letters_ff;
      wlen_in    = wlen_ff;
      index_in   = index_ff + INDEX_BITS'(1);
      handled    = 1'b0;
      pair       = '0;

      case (phase_ff)
         PH_NUM: begin
            if (is_digit || is_dot) begin
               handled = 1'b1;
               if (is_dot) begin
                  if (dot_ff) begin
                     phase_in = PH_ERR;
                     pair = push(pair, make_res(KIND_ERROR, '0, '0, ERR_SECOND_DOT,
                                                EPOS_W'(index_ff)));
                  end else begin
                     dot_in = 1'b1;
                  end
               end else if (dcount_ff >= COUNT_W'(MAX_DIGITS)) begin
                  phase_in = PH_ERR;
                  pair = push(pair, make_res(KIND_ERROR, '0, '0, ERR_TOO_MANY,
                                             EPOS_W'(index_ff)));
               end else begin
                  acc_in    = (acc_ff << 3) + (acc_ff << 1) + MANT_W'(dval);
                  dcount_in = dcount_ff + COUNT_W'(1);
                  if (dot_ff) adot_in = adot_ff + FRAC_W'(1);
               end
            end else begin
               phase_in = PH_IDLE;
               pair = push(pair, make_res(KIND_NUMBER, acc_ff, adot_ff, ERR_NONE, '0));
            end
         end
         PH_WORD: begin
            if (is_letter) begin
               handled = 1'b1;
               if (wlen_ff < WORD_FULL) begin
                  letters_in[wlen_ff[1:0]] = char_code;
                  wlen_in = wlen_ff + 3'd1;
               end else begin
                  wlen_in = WORD_OVER;
               end
            end else if (fn_kind == KIND_ERROR) begin
               // unknown word: the ending character is dropped
               handled  = 1'b1;
               phase_in = PH_ERR;
               pair = push(pair, make_res(KIND_ERROR, '0, '0, ERR_UNKNOWN_FN,
                                          EPOS_W'(idx_prev)));
            end else begin
               phase_in = PH_IDLE;
               pair = push(pair, make_res(fn_kind, '0, '0, ERR_NONE, '0));
            end
         end
         default: ;
      endcase

      if (!handled && phase_in == PH_IDLE) begin
         case (char_code)
            CH_PLUS:   pair = push(pair, make_res(KIND_PLUS, '0, '0, ERR_NONE, '0));
            CH_MINUS:  pair = push(pair, make_res(KIND_MINUS, '0, '0, ERR_NONE, '0));
            CH_MUL:    pair = push(pair, make_res(KIND_MUL, '0, '0, ERR_NONE, '0));
            CH_DIV:    pair = push(pair, make_res(KIND_DIV, '0, '0, ERR_NONE, '0));
            CH_POWER:  pair = push(pair, make_res(KIND_POWER, '0, '0, ERR_NONE, '0));
            CH_LPAREN: pair = push(pair, make_res(KIND_LPAREN, '0, '0, ERR_NONE, '0));
            CH_RPAREN: pair = push(pair, make_res(KIND_RPAREN, '0, '0, ERR_NONE, '0));
            CH_SPACE, CH_TAB, CH_NL: ;
            default: begin
               if (is_digit) begin
                  phase_in  = PH_NUM;
                  acc_in    = MANT_W'(dval);
                  dcount_in = COUNT_W'(1);
                  adot_in   = '0;
                  dot_in    = 1'b0;
               end else if (is_letter) begin
                  phase_in      = PH_WORD;
                  letters_in    = '{default: '0};
                  letters_in[0] = char_code;
                  wlen_in       = 3'd1;
               end else begin
                  phase_in = PH_ERR;
                  pair = push(pair, make_res(KIND_ERROR, '0, '0, ERR_UNEXPECTED,
                                             EPOS_W'(index_ff)));
               end
            end
         endcase
      end

      if (end_of_expression) begin
         // flush whatever token is open, then clear everything
         if (phase_in == PH_NUM) begin
            pair = push(pair, make_res(KIND_NUMBER, acc_in, adot_in, ERR_NONE, '0));
         end else if (phase_in == PH_WORD) begin
            if (word_kind(letters_in[0], letters_in[1], letters_in[2], letters_in[3],
                          wlen_in) == KIND_ERROR) begin
               pair = push(pair, make_res(KIND_ERROR, '0, '0, ERR_UNKNOWN_FN,
                                          EPOS_W'(index_ff)));
            end else begin
               pair = push(pair, make_res(word_kind(letters_in[0], letters_in[1],
                                                    letters_in[2], letters_in[3],
                                                    wlen_in), '0, '0, ERR_NONE, '0));
            end
         end
         phase_in   = PH_IDLE;
         acc_in     = '0;
         dcount_in  = '0;
         adot_in    = '0;
         dot_in     = 1'b0;
         letters_in = '{default: '0};
         wlen_in    = '0;
         index_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         index_ff   <= '0;
         acc_ff     <= '0;
         dcount_ff  <= '0;
         adot_ff    <= '0;
         dot_ff     <= 1'b0;
         letters_ff <= '{default: '0};
         wlen_ff    <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         index_ff   <= index_in;
         acc_ff     <= acc_in;
         dcount_ff  <= dcount_in;
         adot_ff    <= adot_in;
         dot_ff     <= dot_in;
         letters_ff <= letters_in;
         wlen_ff    <= wlen_in;
      end
   end

endmodule

### rtl/met_out_buf.sv
// Two-entry result register that drains one token per cycle while take_ready is high
module met_out_buf import met_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  pair_type   pair,
   input  logic       take_ready,
   output logic       free,
   output logic       out_valid,
   output logic       out_last,
   output result_type out_res
);

   logic [1:0] count_ff;
   result_type first_ff;
   result_type second_ff;
   logic       take;

   assign out_valid = (count_ff != 2'd0);
   assign out_last  = (count_ff == 2'd1);
   assign out_res   = first_ff;
   assign take      = out_valid && take_ready;
   // room for a new pair once the last queued token leaves this cycle
   assign free      = (count_ff == 2'd0) || (count_ff == 2'd1 && take_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (load) begin
         count_ff <= pair.count;
      end else if (take) begin
         count_ff <= count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         first_ff  <= pair.first;
         second_ff <= pair.second;
      end else if (take) begin
         first_ff  <= second_ff;
      end
   end

endmodule

### rtl/math_expression_tokenizer.sv
// Top level of the arithmetic expression tokenizer
//
//   channel   dir   handshake          payload
//   req_ch    in    valid / ready      char_code, end_of_expression
//   rsp_ch    out   valid / ready      token fields, last_of_run
//
// One character is taken per cycle while the result register has room; the
// first token passes through the input register, then the result register.
// A character that yields two tokens holds the result register until its
// second token is taken, so the next request waits behind it.
// The input register takes a request while a token is still pending.
// Reset is synchronous and returns the scanner to idle at index zero.
module math_expression_tokenizer import met_pkg::*; #(
   parameter int MAX_DIGITS = MAX_DIGITS_DEF,
   parameter int INDEX_BITS = INDEX_BITS_DEF
) (
   input logic           clock,
   input logic           reset,
   met_req_if.sink       req_ch,
   met_rsp_if.source     rsp_ch
);

   logic              in_valid_ff;
   logic [CHAR_W-1:0] char_ff;
   logic              eoe_ff;
   logic              free;
   logic              step;
   pair_type          pair;
   result_type        res;
   logic              res_valid;
   logic              res_last;

   assign step         = in_valid_ff && free;
   assign req_ch.ready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.valid && req_ch.ready) begin
         in_valid_ff <= 1'b1;
      end else if (step) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         char_ff <= req_ch.char_code;
         eoe_ff  <= req_ch.end_of_expression;
      end
   end

   met_lexer #(
      .MAX_DIGITS (MAX_DIGITS),
      .INDEX_BITS (INDEX_BITS)
   ) u_lexer (
      .clock             (clock),
      .reset             (reset),
      .step              (step),
      .char_code         (char_ff),
      .end_of_expression (eoe_ff),
      .pair              (pair)
   );

   met_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .load       (step),
      .pair       (pair),
      .take_ready (rsp_ch.ready),
      .free       (free),
      .out_valid  (res_valid),
      .out_last   (res_last),
      .out_res    (res)
   );

   assign rsp_ch.valid           = res_valid;
   assign rsp_ch.token_kind      = res.kind;
   assign rsp_ch.number_mantissa = res.mantissa;
   assign rsp_ch.fraction_digits = res.frac;
   assign rsp_ch.error_code      = res.ecode;
   assign rsp_ch.error_position  = res.epos;
   assign rsp_ch.last_of_run     = res_last;

endmodule

### rtl/met_checker.sv
// Port-level checks of the tokenizer and their binding to the top level
`include "math_expression_tokenizer_assert.svh"

module met_checker import met_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [3:0]        token_kind,
   input logic [MANT_W-1:0] mantissa,
   input logic [FRAC_W-1:0] frac,
   input logic [2:0]        ecode,
   input logic              last
);

   `MET_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(token_kind) && $stable(mantissa) && $stable(last))
   `MET_ASSERT_IMPL(a_err_code, clock, reset, rsp_valid && token_kind == KIND_ERROR, ecode != ERR_NONE && ecode <= ERR_TOO_MANY)
   `MET_ASSERT_IMPL(a_no_err_code, clock, reset, rsp_valid && token_kind != KIND_ERROR, ecode == ERR_NONE)
   `MET_ASSERT_IMPL(a_num_fields, clock, reset, rsp_valid && token_kind != KIND_NUMBER, mantissa == '0 && frac == '0)
   `MET_ASSERT_IMPL(a_frac_range, clock, reset, rsp_valid && token_kind == KIND_NUMBER, frac <= FRAC_CEIL)

endmodule

bind math_expression_tokenizer met_checker u_met_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .token_kind (rsp_ch.token_kind),
   .mantissa   (rsp_ch.number_mantissa),
   .frac       (rsp_ch.fraction_digits),
   .ecode      (rsp_ch.error_code),
   .last       (rsp_ch.last_of_run)
);
